@@ rtl/remote_frame_decoder_key_classifier_core_macros.svh @@
// Assertion macros used by the checker file of the remote frame decoder.
`ifndef REMOTE_FRAME_DECODER_KEY_CLASSIFIER_CORE_MACROS_SVH
`define REMOTE_FRAME_DECODER_KEY_CLASSIFIER_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define RFDKC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define RFDKC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/rfdkc_pkg.sv @@
// Shared constants and types of the remote frame decoder and key classifier.
package rfdkc_pkg;

   localparam int FRAME_BYTES      = 18;
   localparam int KEY_COUNT_DEF    = 18;
   localparam int HOLD_WIDTH_DEF   = 16;
   localparam int FLAG_BITS        = 18;
   localparam int THRESH_W         = 16;
   localparam int DEADBAND_W       = 10;
   localparam int CHANNEL_W        = 11;
   localparam int CSR_DATA_W       = 16;
   localparam int CSR_INDEX_W      = 2;
   localparam int BYTE_COUNT_W     = $clog2(FRAME_BYTES + 2);
   localparam int STORE_IDX_W      = $clog2(FRAME_BYTES);

   // Input transaction kinds
   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_IDLE = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_DEADBAND        = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PRESS_THRESH    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_THRESH     = 2'd2;

   localparam logic [DEADBAND_W-1:0] DEADBAND_RST     = 10'd20;
   localparam logic [THRESH_W-1:0]   PRESS_THRESH_RST = 16'd10;
   localparam logic [THRESH_W-1:0]   LONG_THRESH_RST  = 16'd50;

   typedef struct packed {
      logic [THRESH_W-1:0] press;
      logic [THRESH_W-1:0] long_press;
   } key_thresh_type;

   typedef struct packed {
      logic [FLAG_BITS-1:0] press;
      logic [FLAG_BITS-1:0] long_press;
      logic [FLAG_BITS-1:0] click;
   } key_flags_type;

endpackage

@@ rtl/remote_frame_decoder_key_classifier_core.sv @@
// Top level: remote control frame collector, channel decoder and key classifier.
//
//   channel | ports  | direction | handshake     | payload
//   --------+--------+-----------+---------------+-----------------------------------
//   request | req_*  | in        | valid / ready | action, rx_byte
//   result  | rsp_*  | out       | valid / ready | 5 channels, switches, mouse, flags
//   csr     | csr_*  | in        | write enable  | index, write data
//
// One transaction per cycle is taken. An idle that closes an 18-byte frame is decoded
// from the input register and then loads the result register. Other transactions yield
// nothing. While a result waits on rsp_ready, bytes and rejected idles keep moving; a
// closing idle waits in the input register and holds req_ready low. Reset is synchronous
// and clears control state; the frame byte store is not reset.
module remote_frame_decoder_key_classifier_core
   import rfdkc_pkg::*;
#(
   parameter int KEY_COUNT  = KEY_COUNT_DEF,
   parameter int HOLD_WIDTH = HOLD_WIDTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_action,
   input  logic [7:0]                   req_rx_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [CHANNEL_W-1:0]  rsp_rotate_value,
   output logic signed [CHANNEL_W-1:0]  rsp_tilt_value,
   output logic signed [CHANNEL_W-1:0]  rsp_strafe_value,
   output logic signed [CHANNEL_W-1:0]  rsp_surge_value,
   output logic signed [CHANNEL_W-1:0]  rsp_wheel_value,
   output logic [1:0]                   rsp_switch_left,
   output logic [1:0]                   rsp_switch_right,
   output logic signed [15:0]           rsp_mouse_x,
   output logic signed [15:0]           rsp_mouse_y,
   output logic [FLAG_BITS-1:0]         rsp_press_flags,
   output logic [FLAG_BITS-1:0]         rsp_long_press_flags,
   output logic [FLAG_BITS-1:0]         rsp_click_flags,
   input  logic                         csr_write_en,
   input  logic [CSR_INDEX_W-1:0]       csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_write_data
);

   // Re-center a raw channel by 1024 and zero it inside the deadband
   function automatic logic [CHANNEL_W-1:0] centre(input logic [CHANNEL_W-1:0]  raw,
                                                   input logic [DEADBAND_W-1:0] band);
      logic [CHANNEL_W-1:0] v;
      logic [CHANNEL_W:0]   mag;
      v   = {~raw[CHANNEL_W-1], raw[CHANNEL_W-2:0]};
      mag = v[CHANNEL_W-1] ? (CHANNEL_W+1)'(0) - {1'b1, v} : {1'b0, v};
      if (mag <= (CHANNEL_W+1)'(band))
         v = '0;
      return v;
   endfunction

   // Configuration registers
   logic [DEADBAND_W-1:0] deadband_ff;
   key_thresh_type        thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff          <= DEADBAND_RST;
         thresh_ff.press      <= PRESS_THRESH_RST;
         thresh_ff.long_press <= LONG_THRESH_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_DEADBAND:     deadband_ff          <= csr_write_data[DEADBAND_W-1:0];
            CSR_PRESS_THRESH: thresh_ff.press      <= csr_write_data[THRESH_W-1:0];
            CSR_LONG_THRESH:  thresh_ff.long_press <= csr_write_data[THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // Input register
   logic       in_valid_ff;
   logic       in_action_ff;
   logic [7:0] in_byte_ff;

   logic [BYTE_COUNT_W-1:0] byte_count_ff, byte_count_in;
   logic [7:0]              frame_store_ff [FRAME_BYTES];
   logic                    produces, out_free, advance, store_wr;
   logic                    rsp_valid_ff, rsp_valid_in;

   assign produces  = (in_action_ff == ACTION_IDLE) &&
                      (byte_count_ff == BYTE_COUNT_W'(FRAME_BYTES));
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!produces || out_free);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_action_ff <= req_action;
         in_byte_ff   <= req_rx_byte;
      end
   end

   // Byte collection; count saturates one past a full frame so that it is rejected
   assign store_wr = advance && (in_action_ff == ACTION_BYTE) &&
                     (byte_count_ff < BYTE_COUNT_W'(FRAME_BYTES));

   always_comb begin
      byte_count_in = byte_count_ff;
      if (advance) begin
         if (in_action_ff == ACTION_IDLE)
            byte_count_in = '0;
         else if (byte_count_ff <= BYTE_COUNT_W'(FRAME_BYTES))
            byte_count_in = byte_count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff <= '0;
      end else begin
         byte_count_ff <= byte_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (store_wr)
         frame_store_ff[byte_count_ff[STORE_IDX_W-1:0]] <= in_byte_ff;
   end

   // Frame field extraction
   logic [CHANNEL_W-1:0] raw_ch0, raw_ch1, raw_ch2, raw_ch3, raw_wheel;
   logic [FLAG_BITS-1:0] key_down;
   key_flags_type        flags_next;

   assign raw_ch0   = {frame_store_ff[1][2:0], frame_store_ff[0]};
   assign raw_ch1   = {frame_store_ff[2][5:0], frame_store_ff[1][7:3]};
   assign raw_ch2   = {frame_store_ff[4][0], frame_store_ff[3], frame_store_ff[2][7:6]};
   assign raw_ch3   = {frame_store_ff[5][3:0], frame_store_ff[4][7:1]};
   assign raw_wheel = {frame_store_ff[17][2:0], frame_store_ff[16]};
   assign key_down  = {|frame_store_ff[13], |frame_store_ff[12],
                       frame_store_ff[15], frame_store_ff[14]};

   rfdkc_key_classifier #(
      .KEY_COUNT  (KEY_COUNT),
      .HOLD_WIDTH (HOLD_WIDTH)
   ) u_key_classifier (
      .clock      (clock),
      .reset      (reset),
      .update_en  (advance && produces),
      .key_down   (key_down),
      .thresh     (thresh_ff),
      .flags_next (flags_next)
   );

   // Result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && produces)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && produces) begin
         rsp_rotate_value     <= centre(raw_ch0, deadband_ff);
         rsp_tilt_value       <= centre(raw_ch1, deadband_ff);
         rsp_strafe_value     <= centre(raw_ch2, deadband_ff);
         rsp_surge_value      <= centre(raw_ch3, deadband_ff);
         rsp_wheel_value      <= centre(raw_wheel, deadband_ff);
         rsp_switch_left      <= frame_store_ff[5][7:6];
         rsp_switch_right     <= frame_store_ff[5][5:4];
         rsp_mouse_x          <= {frame_store_ff[7], frame_store_ff[6]};
         rsp_mouse_y          <= {frame_store_ff[9], frame_store_ff[8]};
         rsp_press_flags      <= flags_next.press;
         rsp_long_press_flags <= flags_next.long_press;
         rsp_click_flags      <= flags_next.click;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/rfdkc_key_classifier.sv @@
// Per-key hold counters with press, long-press and click flags.
module rfdkc_key_classifier
   import rfdkc_pkg::*;
#(
   parameter int KEY_COUNT  = KEY_COUNT_DEF,
   parameter int HOLD_WIDTH = HOLD_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 update_en,
   input  logic [FLAG_BITS-1:0] key_down,
   input  key_thresh_type       thresh,
   output key_flags_type        flags_next
);

   localparam int CMP_W = (HOLD_WIDTH > THRESH_W) ? HOLD_WIDTH : THRESH_W;
   localparam logic [HOLD_WIDTH-1:0] HOLD_MAX = {HOLD_WIDTH{1'b1}};

   logic [HOLD_WIDTH-1:0] hold_count_ff [KEY_COUNT];
   logic [HOLD_WIDTH-1:0] hold_count_in [KEY_COUNT];
   logic [KEY_COUNT-1:0]  press_ff, press_in;
   logic [KEY_COUNT-1:0]  long_ff, long_in;
   logic [KEY_COUNT-1:0]  click_ff, click_in;
   logic [KEY_COUNT-1:0]  down;
   logic [CMP_W-1:0]      press_cmp, long_cmp;

   assign press_cmp = CMP_W'(thresh.press);
   assign long_cmp  = CMP_W'(thresh.long_press);

   for (genvar i = 0; i < KEY_COUNT; i++) begin : g_key
      logic [HOLD_WIDTH-1:0] held;
      logic [CMP_W-1:0]      old_cmp, new_cmp;

      // Keys beyond the frame's key bits are never down
      if (i < FLAG_BITS) begin : g_map
         assign down[i] = key_down[i];
      end else begin : g_none
         assign down[i] = 1'b0;
      end

      assign held    = (hold_count_ff[i] != HOLD_MAX) ? hold_count_ff[i] + 1'b1
                                                      : hold_count_ff[i];
      assign old_cmp = CMP_W'(hold_count_ff[i]);
      assign new_cmp = CMP_W'(held);

      always_comb begin
         hold_count_in[i] = hold_count_ff[i];
         press_in[i]      = press_ff[i];
         long_in[i]       = long_ff[i];
         click_in[i]      = click_ff[i];
         if (update_en) begin
            if (down[i]) begin
               hold_count_in[i] = held;
               press_in[i]      = press_ff[i] | (new_cmp > press_cmp);
               long_in[i]       = long_ff[i] | (new_cmp > long_cmp);
            end else begin
               hold_count_in[i] = '0;
               press_in[i]      = 1'b0;
               long_in[i]       = 1'b0;
               click_in[i]      = (old_cmp > press_cmp) && (old_cmp < long_cmp);
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            hold_count_ff[i] <= '0;
            press_ff[i]      <= 1'b0;
            long_ff[i]       <= 1'b0;
            click_ff[i]      <= 1'b0;
         end else begin
            hold_count_ff[i] <= hold_count_in[i];
            press_ff[i]      <= press_in[i];
            long_ff[i]       <= long_in[i];
            click_ff[i]      <= click_in[i];
         end
      end
   end

   for (genvar b = 0; b < FLAG_BITS; b++) begin : g_flag
      if (b < KEY_COUNT) begin : g_live
         assign flags_next.press[b]      = press_in[b];
         assign flags_next.long_press[b] = long_in[b];
         assign flags_next.click[b]      = click_in[b];
      end else begin : g_zero
         assign flags_next.press[b]      = 1'b0;
         assign flags_next.long_press[b] = 1'b0;
         assign flags_next.click[b]      = 1'b0;
      end
   end

endmodule

@@ rtl/rfdkc_checker.sv @@
// Port-level checks of the remote frame decoder top level, bound to it.
`include "remote_frame_decoder_key_classifier_core_macros.svh"

module rfdkc_checker
   import rfdkc_pkg::*;
(
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         req_action,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [CHANNEL_W-1:0]  rsp_rotate_value,
   input logic signed [CHANNEL_W-1:0]  rsp_wheel_value,
   input logic signed [15:0]           rsp_mouse_x,
   input logic [FLAG_BITS-1:0]         rsp_press_flags,
   input logic [FLAG_BITS-1:0]         rsp_click_flags
);

   // A held result keeps its payload
   `RFDKC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_rotate_value) && $stable(rsp_wheel_value) && $stable(rsp_mouse_x) && $stable(rsp_press_flags) && $stable(rsp_click_flags), "result changed while stalled")

   // Reset empties the result channel
   `RFDKC_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid, "result valid after reset")

   // A fresh result follows an accepted idle transaction
   `RFDKC_ASSERT_IMPLY(a_rsp_cause, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready && (req_action == ACTION_IDLE), 2), "result without a closing idle")

   // With the result channel empty the block always takes a transaction
   `RFDKC_ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_valid, req_ready, "request stalled with empty output")

endmodule

bind remote_frame_decoder_key_classifier_core rfdkc_checker u_rfdkc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_action       (req_action),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_rotate_value (rsp_rotate_value),
   .rsp_wheel_value  (rsp_wheel_value),
   .rsp_mouse_x      (rsp_mouse_x),
   .rsp_press_flags  (rsp_press_flags),
   .rsp_click_flags  (rsp_click_flags)
);

@@ tb/remote_frame_decoder_key_classifier_core_tb.sv @@
// Testbench for the remote frame decoder: random byte/idle traffic checked against a predictor.
`timescale 1ns / 1ps

module remote_frame_decoder_key_classifier_core_tb;
   import rfdkc_pkg::*;

   localparam int CYCLE_LIMIT       = 400000;
   localparam int LONG_STALL_CYCLES = 300;
   localparam int SETTLE_CYCLES     = 4;
   localparam int IDLE_PERCENT      = 28;
   localparam int CHANNEL_CENTRE    = 1024;

   typedef struct packed {
      logic       action;
      logic [7:0] data;
   } rx_item_type;

   typedef struct {
      logic signed [CHANNEL_W-1:0] rotate;
      logic signed [CHANNEL_W-1:0] tilt;
      logic signed [CHANNEL_W-1:0] strafe;
      logic signed [CHANNEL_W-1:0] surge;
      logic signed [CHANNEL_W-1:0] wheel;
      logic [1:0]                  switch_left;
      logic [1:0]                  switch_right;
      logic signed [15:0]          mouse_x;
      logic signed [15:0]          mouse_y;
      logic [FLAG_BITS-1:0]        press;
      logic [FLAG_BITS-1:0]        long_press;
      logic [FLAG_BITS-1:0]        click;
   } decoded_frame_type;

   logic                        clock = 1'b0;
   logic                        reset = 1'b1;
   logic                        req_valid = 1'b0;
   logic                        req_ready;
   logic                        req_action = ACTION_BYTE;
   logic [7:0]                  req_rx_byte = 8'h00;
   logic                        rsp_valid;
   logic                        rsp_ready = 1'b0;
   logic signed [CHANNEL_W-1:0] rsp_rotate_value;
   logic signed [CHANNEL_W-1:0] rsp_tilt_value;
   logic signed [CHANNEL_W-1:0] rsp_strafe_value;
   logic signed [CHANNEL_W-1:0] rsp_surge_value;
   logic signed [CHANNEL_W-1:0] rsp_wheel_value;
   logic [1:0]                  rsp_switch_left;
   logic [1:0]                  rsp_switch_right;
   logic signed [15:0]          rsp_mouse_x;
   logic signed [15:0]          rsp_mouse_y;
   logic [FLAG_BITS-1:0]        rsp_press_flags;
   logic [FLAG_BITS-1:0]        rsp_long_press_flags;
   logic [FLAG_BITS-1:0]        rsp_click_flags;
   logic                        csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0]      csr_index = CSR_DEADBAND;
   logic [CSR_DATA_W-1:0]       csr_write_data = '0;

   // Predictor state and its copy of the registers
   logic [7:0]                  rx_store [FRAME_BYTES];
   logic [4:0]                  rx_count = '0;
   logic [HOLD_WIDTH_DEF-1:0]   hold_frames [FLAG_BITS];
   logic [FLAG_BITS-1:0]        pressed = '0;
   logic [FLAG_BITS-1:0]        long_pressed = '0;
   logic [FLAG_BITS-1:0]        clicked = '0;
   logic [DEADBAND_W-1:0]       deadband_cfg = DEADBAND_RST;
   logic [THRESH_W-1:0]         press_thr = PRESS_THRESH_RST;
   logic [THRESH_W-1:0]         long_thr = LONG_THRESH_RST;

   rx_item_type                 pending_rx [$];
   decoded_frame_type           expected_frames [$];
   rx_item_type                 next_item;
   decoded_frame_type           want;

   logic [7:0]                  stim_frame [FRAME_BYTES];
   logic [FLAG_BITS-1:0]        held_keys = '0;
   logic                        steady_traffic = 1'b0;
   logic                        request_long_stall = 1'b0;
   logic                        long_stall_done = 1'b0;
   int                          long_stall_left = 0;

   int                          cycle_count = 0;
   int                          items_queued = 0;
   int                          items_accepted = 0;
   int                          frames_checked = 0;
   int                          frames_dropped = 0;
   int                          settings_used = 1;
   int                          mismatches = 0;

   remote_frame_decoder_key_classifier_core dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_action             (req_action),
      .req_rx_byte            (req_rx_byte),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_rotate_value       (rsp_rotate_value),
      .rsp_tilt_value         (rsp_tilt_value),
      .rsp_strafe_value       (rsp_strafe_value),
      .rsp_surge_value        (rsp_surge_value),
      .rsp_wheel_value        (rsp_wheel_value),
      .rsp_switch_left        (rsp_switch_left),
      .rsp_switch_right       (rsp_switch_right),
      .rsp_mouse_x            (rsp_mouse_x),
      .rsp_mouse_y            (rsp_mouse_y),
      .rsp_press_flags        (rsp_press_flags),
      .rsp_long_press_flags   (rsp_long_press_flags),
      .rsp_click_flags        (rsp_click_flags),
      .csr_write_en           (csr_write_en),
      .csr_index              (csr_index),
      .csr_write_data         (csr_write_data)
   );

   always #10 clock = ~clock;

   initial begin
      for (int i = 0; i < FLAG_BITS; i++) hold_frames[i] = '0;
   end

   function automatic logic signed [CHANNEL_W-1:0] centre_channel(input logic [CHANNEL_W-1:0] raw);
      int v;
      int mag;
      v = int'(raw) - CHANNEL_CENTRE;
      mag = (v < 0) ? -v : v;
      if (mag <= int'(deadband_cfg)) v = 0;
      return v[CHANNEL_W-1:0];
   endfunction

   // Track one accepted transaction; a complete frame closed by idle yields a decoded frame.
   task automatic decode_and_classify(input logic action, input logic [7:0] data);
      decoded_frame_type    f;
      logic [FLAG_BITS-1:0] down;
      int                   k;
      if (action == ACTION_BYTE) begin
         if (rx_count < FRAME_BYTES) rx_store[rx_count] = data;
         if (rx_count <= FRAME_BYTES) rx_count++;
      end else if (rx_count != FRAME_BYTES) begin
         rx_count = '0;
         frames_dropped++;
      end else begin
         rx_count = '0;
         f.rotate       = centre_channel({rx_store[1][2:0], rx_store[0]});
         f.tilt         = centre_channel({rx_store[2][5:0], rx_store[1][7:3]});
         f.strafe       = centre_channel({rx_store[4][0], rx_store[3], rx_store[2][7:6]});
         f.surge        = centre_channel({rx_store[5][3:0], rx_store[4][7:1]});
         f.wheel        = centre_channel({rx_store[17][2:0], rx_store[16]});
         f.switch_left  = rx_store[5][7:6];
         f.switch_right = rx_store[5][5:4];
         f.mouse_x      = {rx_store[7], rx_store[6]};
         f.mouse_y      = {rx_store[9], rx_store[8]};
         // mouse buttons count as down on any nonzero byte
         down = {rx_store[13] != 8'h00, rx_store[12] != 8'h00, rx_store[15], rx_store[14]};
         for (k = 0; k < FLAG_BITS; k++) begin
            if (down[k]) begin
               if (hold_frames[k] != '1) hold_frames[k]++;
               if (hold_frames[k] > press_thr) pressed[k] = 1'b1;
               if (hold_frames[k] > long_thr) long_pressed[k] = 1'b1;
            end else begin
               clicked[k]      = (hold_frames[k] > press_thr) && (hold_frames[k] < long_thr);
               pressed[k]      = 1'b0;
               long_pressed[k] = 1'b0;
               hold_frames[k]  = '0;
            end
         end
         f.press      = pressed;
         f.long_press = long_pressed;
         f.click      = clicked;
         expected_frames.push_back(f);
      end
   endtask

   task automatic check_field(input string name, input logic signed [31:0] exp_v,
                              input logic signed [31:0] act_v);
      if (act_v !== exp_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         mismatches++;
      end
   endtask

   // Driver: advance to the next pending transaction once the current one is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_rx.size() > 0 &&
             (steady_traffic || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            next_item = pending_rx.pop_front();
            req_valid   <= 1'b1;
            req_action  <= next_item.action;
            req_rx_byte <= next_item.data;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure plus one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (long_stall_left > 0) begin
         rsp_ready       <= 1'b0;
         long_stall_left <= long_stall_left - 1;
      end else if (request_long_stall && !long_stall_done) begin
         rsp_ready       <= 1'b0;
         long_stall_left <= LONG_STALL_CYCLES;
         long_stall_done <= 1'b1;
      end else begin
         rsp_ready <= steady_traffic || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Monitor: predict on accepted requests, compare accepted results
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            decode_and_classify(req_action, req_rx_byte);
            items_accepted++;
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_frames.size() == 0) begin
               $error("result transaction with no decoded frame outstanding");
               mismatches++;
            end else begin
               want = expected_frames.pop_front();
               check_field("rotate_value", want.rotate, rsp_rotate_value);
               check_field("tilt_value", want.tilt, rsp_tilt_value);
               check_field("strafe_value", want.strafe, rsp_strafe_value);
               check_field("surge_value", want.surge, rsp_surge_value);
               check_field("wheel_value", want.wheel, rsp_wheel_value);
               check_field("switch_left", want.switch_left, rsp_switch_left);
               check_field("switch_right", want.switch_right, rsp_switch_right);
               check_field("mouse_x", want.mouse_x, rsp_mouse_x);
               check_field("mouse_y", want.mouse_y, rsp_mouse_y);
               check_field("press_flags", want.press, rsp_press_flags);
               check_field("long_press_flags", want.long_press, rsp_long_press_flags);
               check_field("click_flags", want.click, rsp_click_flags);
               frames_checked++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("remote_frame_decoder_key_classifier_core test failed");
         $finish;
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      case (idx)
         CSR_DEADBAND:     deadband_cfg = value[DEADBAND_W-1:0];
         CSR_PRESS_THRESH: press_thr = value;
         CSR_LONG_THRESH:  long_thr = value;
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_registers(input logic [DEADBAND_W-1:0] db, input logic [THRESH_W-1:0] pt,
                                input logic [THRESH_W-1:0] lt);
      write_csr(CSR_DEADBAND, CSR_DATA_W'(db));
      write_csr(CSR_PRESS_THRESH, pt);
      write_csr(CSR_LONG_THRESH, lt);
      settings_used++;
   endtask

   // Hold until everything is sent and checked, then let the pipeline drain
   task automatic wait_quiet();
      do @(negedge clock);
      while (pending_rx.size() != 0 || req_valid || expected_frames.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic queue_item(input logic action, input logic [7:0] data);
      pending_rx.push_back('{action, data});
      items_queued++;
   endtask

   function automatic logic [CHANNEL_W-1:0] pick_channel();
      int sel;
      int off;
      sel = $urandom_range(0, 6);
      off = int'(deadband_cfg);
      case (sel)
         0: return CHANNEL_W'(CHANNEL_CENTRE + off);
         1: return CHANNEL_W'(CHANNEL_CENTRE + off + 1);
         2: return CHANNEL_W'(CHANNEL_CENTRE - off);
         3: return CHANNEL_W'(CHANNEL_CENTRE - off - 1);
         4: return ($urandom_range(0, 1) != 0) ? '1 : '0;
         default: return CHANNEL_W'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_mouse();
      case ($urandom_range(0, 3))
         0: return 16'h8000;
         1: return 16'h7FFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Build a frame from field values or fill it with all zeros or all ones; held keys drift slowly so counters climb
   task automatic fill_frame();
      logic [47:0]          sticks;
      logic [CHANNEL_W-1:0] wheel;
      logic [15:0]          mx;
      logic [15:0]          my;
      int                   mode;
      int                   k;
      mode = $urandom_range(0, 11);
      if (mode < 2) begin
         for (k = 0; k < FRAME_BYTES; k++) stim_frame[k] = (mode == 0) ? 8'h00 : 8'hFF;
      end else begin
         held_keys ^= FLAG_BITS'($urandom & $urandom & $urandom);
         sticks = {2'($urandom), 2'($urandom), pick_channel(), pick_channel(),
                   pick_channel(), pick_channel()};
         for (k = 0; k < 6; k++) stim_frame[k] = sticks[8*k +: 8];
         mx = pick_mouse();
         my = pick_mouse();
         stim_frame[6]  = mx[7:0];
         stim_frame[7]  = mx[15:8];
         stim_frame[8]  = my[7:0];
         stim_frame[9]  = my[15:8];
         stim_frame[10] = 8'($urandom);
         stim_frame[11] = 8'($urandom);
         stim_frame[12] = held_keys[16] ? 8'($urandom_range(1, 255)) : 8'h00;
         stim_frame[13] = held_keys[17] ? 8'($urandom_range(1, 255)) : 8'h00;
         stim_frame[14] = held_keys[7:0];
         stim_frame[15] = held_keys[15:8];
         wheel = pick_channel();
         stim_frame[16] = wheel[7:0];
         stim_frame[17] = {5'($urandom), wheel[10:8]};
      end
   endtask

   // Send n_bytes of the current frame (extra bytes are random), then the idle
   task automatic queue_frame(input int n_bytes);
      int k;
      for (k = 0; k < n_bytes; k++)
         queue_item(ACTION_BYTE, (k < FRAME_BYTES) ? stim_frame[k] : 8'($urandom));
      queue_item(ACTION_IDLE, 8'($urandom));
   endtask

   task automatic queue_random_traffic(input int n_items);
      int stop_at;
      int pick;
      stop_at = items_queued + n_items;
      while (items_queued < stop_at) begin
         pick = $urandom_range(0, 99);
         fill_frame();
         if (pick < 84) queue_frame(FRAME_BYTES);
         else if (pick < 91) queue_frame($urandom_range(0, FRAME_BYTES - 1));
         else if (pick < 97) queue_frame($urandom_range(FRAME_BYTES + 1, FRAME_BYTES + 5));
         else queue_item(ACTION_IDLE, 8'($urandom));
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      do @(negedge clock); while (reset);

      // idle with nothing collected, a full frame of ones, a short frame
      queue_item(ACTION_IDLE, 8'hFF);
      for (int k = 0; k < FRAME_BYTES; k++) stim_frame[k] = 8'hFF;
      queue_frame(FRAME_BYTES);
      queue_frame(2);
      wait_quiet();

      queue_random_traffic(200);
      wait_quiet();

      set_registers('0, '0, '0);
      steady_traffic = 1'b1;
      queue_random_traffic(150);
      wait_quiet();
      steady_traffic = 1'b0;

      // low thresholds make clicks and long presses common; fill the block under hold-off
      set_registers('1, 16'd2, 16'd6);
      request_long_stall = 1'b1;
      queue_random_traffic(250);
      wait_quiet();

      set_registers(10'd511, '1, '1);
      queue_random_traffic(80);
      wait_quiet();

      set_registers(DEADBAND_W'($urandom_range(0, 1023)), 16'd4, 16'd1);
      queue_random_traffic(80);
      wait_quiet();

      $display("Ran %0d transactions over %0d register settings in %0d cycles:",
               items_accepted, settings_used, cycle_count);
      $display("%0d decoded frames checked, %0d malformed frames dropped",
               frames_checked, frames_dropped);
      if (mismatches == 0) begin
         $display("remote_frame_decoder_key_classifier_core test passed");
      end else begin
         $display("remote_frame_decoder_key_classifier_core test failed");
      end
      $finish;
   end

endmodule

@@ remote_frame_decoder_key_classifier_core.f @@
+incdir+rtl
rtl/rfdkc_pkg.sv
rtl/rfdkc_key_classifier.sv
rtl/remote_frame_decoder_key_classifier_core.sv
rtl/rfdkc_checker.sv
tb/remote_frame_decoder_key_classifier_core_tb.sv
